// ===== src/ptts_pkg.sv =====
// Shared constants for the periodic task tick scheduler.
`default_nettype none

package ptts_pkg;

  // Operation codes carried in the request's func field
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_RESUME  = 3'd2;
  localparam logic [2:0] OP_SUSPEND = 3'd3;
  localparam logic [2:0] OP_KILL    = 3'd4;

  localparam int FUNC_W  = 3;
  localparam int ID_W    = 3;
  localparam int TIME_W  = 16;
  localparam int MASK_W  = 8;

  localparam int TASK_COUNT_DEF = 8;

endpackage

`default_nettype wire

// ===== src/ptts_if.sv =====
// Request and response channel interfaces of the tick scheduler.
`default_nettype none

interface ptts_req_if;
  logic                              valid;
  logic                              ready;
  logic [ptts_pkg::FUNC_W-1:0]       func;
  logic [ptts_pkg::ID_W-1:0]         task_id;
  logic [ptts_pkg::TIME_W-1:0]       period;
  logic [ptts_pkg::TIME_W-1:0]       first_delay;

  modport source (output valid, func, task_id, period, first_delay, input ready);
  modport sink   (input valid, func, task_id, period, first_delay, output ready);
endinterface

interface ptts_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ptts_pkg::MASK_W-1:0]       fire_mask;
  logic                              create_accepted;

  modport source (output valid, fire_mask, create_accepted, input ready);
  modport sink   (input valid, fire_mask, create_accepted, output ready);
endinterface

`default_nettype wire

// ===== src/ptts_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ptts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler: slot table walk and control.
// Response: a create, resume, suspend, kill or unknown request is answered
//   in the cycle after acceptance; a tick is answered once the walk, one slot
//   per cycle through the slot RAM, is done and the response register is free.
// Throughput: one request at a time; the next one is taken as soon as the
//   response register is free or being drained.
// Reset: synchronous, active low; clears all used and ready marks, the FSM and
//   the response valid. The slot RAM needs no clearing.
`default_nettype none

module periodic_task_tick_scheduler #(
  parameter int TASK_COUNT = ptts_pkg::TASK_COUNT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ptts_req_if.sink    in_req,
  ptts_rsp_if.source  out_rsp
);

  localparam int TW    = ptts_pkg::TIME_W;
  localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CNT_W = $clog2(TASK_COUNT + 1);
  localparam int RAM_W = 2 * TW;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;      // next slot to read
  logic                        pend_r, pend_nxt;    // read data due this cycle
  logic [IDX_W-1:0]            pslot_r, pslot_nxt;  // slot whose data is due
  logic [TASK_COUNT-1:0]       used_r, used_nxt;
  logic [TASK_COUNT-1:0]       ready_r, ready_nxt;
  logic [ptts_pkg::MASK_W-1:0] fire_r, fire_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ptts_pkg::MASK_W-1:0] out_fire_r, out_fire_nxt;
  logic                        out_acc_r, out_acc_nxt;

  // Slot RAM: each entry holds {reload period, countdown}
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [RAM_W-1:0]            ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [RAM_W-1:0]            ram_rdata;

  logic [TW-1:0]               rd_cd;
  logic [TW-1:0]               rd_per;
  logic [TW-1:0]               new_cd;
  logic                        out_free;
  logic                        in_acc;
  logic                        id_ok;
  logic [IDX_W-1:0]            id;
  logic                        hit;

  ptts_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TASK_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_cd  = ram_rdata[TW-1:0];
  assign rd_per = ram_rdata[RAM_W-1:TW];
  // Fire reloads period - 1 (period zero wraps to all ones), else count down
  assign new_cd = (rd_cd == '0) ? (rd_per - TW'(1)) : (rd_cd - TW'(1));

  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc       = in_req.valid && in_req.ready;
  assign id_ok        = 32'(in_req.task_id) < TASK_COUNT;
  assign id           = IDX_W'(in_req.task_id);
  assign hit          = pend_r && used_r[pslot_r] && ready_r[pslot_r];

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.fire_mask       = out_fire_r;
  assign out_rsp.create_accepted = out_acc_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pslot_nxt     = pslot_r;
    used_nxt      = used_r;
    ready_nxt     = ready_r;
    fire_nxt      = fire_r;
    out_valid_nxt = out_valid_r;
    out_fire_nxt  = out_fire_r;
    out_acc_nxt   = out_acc_r;
    ram_we        = 1'b0;
    ram_waddr     = pslot_r;
    ram_wdata     = {rd_per, new_cd};
    ram_raddr     = cnt_r[IDX_W-1:0];

    // Drop the response once the sink takes it
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.func == ptts_pkg::OP_TICK) begin
            // Start the walk: issue the read of slot 0 now
            state_nxt = ST_WALK;
            ram_raddr = '0;
            cnt_nxt   = CNT_W'(1);
            pend_nxt  = 1'b1;
            pslot_nxt = '0;
            fire_nxt  = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_fire_nxt  = '0;
            out_acc_nxt   = 1'b0;
            if (id_ok) begin
              case (in_req.func)
                ptts_pkg::OP_CREATE: begin
                  if (!used_r[id]) begin
                    used_nxt[id]  = 1'b1;
                    ready_nxt[id] = 1'b1;
                    ram_we        = 1'b1;
                    ram_waddr     = id;
                    ram_wdata     = {in_req.period, in_req.first_delay};
                    out_acc_nxt   = 1'b1;
                  end
                end
                ptts_pkg::OP_RESUME:  ready_nxt[id] = 1'b1;
                ptts_pkg::OP_SUSPEND: ready_nxt[id] = 1'b0;
                ptts_pkg::OP_KILL:    used_nxt[id]  = 1'b0;
                default: ;
              endcase
            end
          end
        end
      end

      ST_WALK: begin
        if (pend_r) begin
          // Write back the slot whose data arrived; free or suspended slots hold
          if (hit) begin
            ram_we = 1'b1;
            if (rd_cd == '0) begin
              for (int b = 0; b < ptts_pkg::MASK_W; b++) begin
                if (b < TASK_COUNT && pslot_r == IDX_W'(b)) begin
                  fire_nxt[b] = 1'b1;
                end
              end
            end
          end
          // Advance the read pointer while slots remain
          if (32'(cnt_r) < TASK_COUNT) begin
            pslot_nxt = cnt_r[IDX_W-1:0];
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fire_nxt  = fire_r;
          out_acc_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      used_r      <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pslot_r    <= pslot_nxt;
    fire_r     <= fire_nxt;
    out_fire_r <= out_fire_nxt;
    out_acc_r  <= out_acc_nxt;
  end

`ifndef SYNTHESIS
  // A tick request always starts a walk
  a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.func == ptts_pkg::OP_TICK) |=> (state_r == ST_WALK))
    else $error("tick did not start a walk");

  // RAM writes stay inside the slot table
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < TASK_COUNT))
    else $error("slot RAM write out of range");

  // A response never reports both a firing and an accepted create
  a_rsp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !((|out_rsp.fire_mask) && out_rsp.create_accepted))
    else $error("response mixes tick and create results");

  // Walk writes happen only for used, ready slots
  a_walk_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_WALK) |-> (used_r[pslot_r] && ready_r[pslot_r]))
    else $error("walk wrote an inactive slot");
`endif

endmodule

`default_nettype wire

// ===== test/periodic_task_tick_scheduler_tb.sv =====
// Self-checking testbench for the periodic task tick scheduler.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

  localparam int TASK_COUNT = ptts_pkg::TASK_COUNT_DEF;
  // Codes outside the defined operation set; the block must answer them with all zeros
  localparam logic [ptts_pkg::FUNC_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [ptts_pkg::FUNC_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [ptts_pkg::FUNC_W-1:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_REQS = 930;
  // Slowest legal spacing is the longest request gap, a full tick walk and the
  // longest response stall; allow many times that before declaring a hang.
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [ptts_pkg::FUNC_W-1:0] func;
    logic [ptts_pkg::ID_W-1:0]   task_id;
    logic [ptts_pkg::TIME_W-1:0] period;
    logic [ptts_pkg::TIME_W-1:0] first_delay;
  } sched_req_t;

  typedef struct packed {
    logic [ptts_pkg::MASK_W-1:0] fire_mask;
    logic                        create_accepted;
  } sched_rsp_t;

  // One directed request; typed rows carry a hand-written response,
  // the others are left to the slot-table model.
  typedef struct packed {
    sched_req_t rq;
    bit         typed;
    sched_rsp_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // tick straight out of reset: nothing is used, nothing fires
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    // create with period zero and immediate first firing
    '{'{ptts_pkg::OP_CREATE,  3'd0, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b1}},
    // create on a used slot is refused
    '{'{ptts_pkg::OP_CREATE,  3'd0, 16'h0005, 16'h0005}, 1'b1, '{8'h00, 1'b0}},
    // top slot with the largest period and delay
    '{'{ptts_pkg::OP_CREATE,  3'd7, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'h00, 1'b1}},
    // slot 0 is due now; slot 7 only counts down
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b1, '{8'h01, 1'b0}},
    '{'{ptts_pkg::OP_CREATE,  3'd3, 16'h0001, 16'h0000}, 1'b1, '{8'h00, 1'b1}},
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_SUSPEND, 3'd3, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    // suspended slot holds its countdown
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_RESUME,  3'd3, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    // kill frees the slot but keeps its ready mark
    '{'{ptts_pkg::OP_KILL,    3'd3, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
    // kill, resume and suspend on free slots
    '{'{ptts_pkg::OP_KILL,    3'd5, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_RESUME,  3'd5, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_SUSPEND, 3'd6, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    // undefined operation codes
    '{'{OP_RSVD5,             3'd2, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'h00, 1'b0}},
    '{'{OP_RSVD6,             3'd7, 16'hFFFF, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    '{'{OP_RSVD7,             3'd0, 16'h0000, 16'hFFFF}, 1'b1, '{8'h00, 1'b0}},
    // refill the killed slot, and fill one whose ready mark was set while free
    '{'{ptts_pkg::OP_CREATE,  3'd3, 16'h0002, 16'h0001}, 1'b1, '{8'h00, 1'b1}},
    '{'{ptts_pkg::OP_CREATE,  3'd5, 16'h0003, 16'h0000}, 1'b1, '{8'h00, 1'b1}},
    '{'{ptts_pkg::OP_SUSPEND, 3'd0, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
    '{'{ptts_pkg::OP_TICK,    3'd0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptts_req_if req_ch ();
  ptts_rsp_if rsp_ch ();

  periodic_task_tick_scheduler #(
    .TASK_COUNT(TASK_COUNT)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  always #4 clk = ~clk;

  // Slot table mirror: marks, countdowns and reload periods
  bit                          slot_used_m  [TASK_COUNT];
  bit                          slot_ready_m [TASK_COUNT];
  logic [ptts_pkg::TIME_W-1:0] countdown_m  [TASK_COUNT];
  logic [ptts_pkg::TIME_W-1:0] reload_m     [TASK_COUNT];

  // Responses owed by the block, oldest first
  sched_rsp_t owed_rsp_q [$];

  int errors = 0;
  int n_reqs = 0;
  int n_ticks = 0;
  int n_fires = 0;
  int n_created = 0;
  int n_rsps = 0;
  int quiet_cycles = 0;

  // Apply one request to the mirrored slot table and return the response it earns.
  function automatic sched_rsp_t schedule_step(input sched_req_t rq);
    sched_rsp_t r;
    int         s;
    r = '0;
    s = int'(rq.task_id);
    if (rq.func == ptts_pkg::OP_TICK) begin
      // Walk every slot; only used, ready slots move
      for (int i = 0; i < TASK_COUNT; i++) begin
        if (slot_used_m[i] && slot_ready_m[i]) begin
          if (countdown_m[i] == '0) begin
            countdown_m[i] = reload_m[i] - 1'b1;  // period zero wraps to all ones
            if (i < ptts_pkg::MASK_W) r.fire_mask[i] = 1'b1;
          end else begin
            countdown_m[i] = countdown_m[i] - 1'b1;
          end
        end
      end
    end else if (s < TASK_COUNT) begin
      case (rq.func)
        ptts_pkg::OP_CREATE: begin
          if (!slot_used_m[s]) begin
            reload_m[s]       = rq.period;
            countdown_m[s]    = rq.first_delay;
            slot_used_m[s]    = 1'b1;
            slot_ready_m[s]   = 1'b1;
            r.create_accepted = 1'b1;
          end
        end
        ptts_pkg::OP_RESUME:  slot_ready_m[s] = 1'b1;
        ptts_pkg::OP_SUSPEND: slot_ready_m[s] = 1'b0;
        ptts_pkg::OP_KILL:    slot_used_m[s] = 1'b0;
        default: ;  // undefined codes leave the table alone
      endcase
    end
    return r;
  endfunction

  // Sender idle control: alternate stretches with and without gaps
  bit req_gaps_on = 1'b1;

  // Present one request, hold it until taken, then log what it should produce.
  task automatic issue(input sched_req_t rq, input bit typed, input sched_rsp_t want);
    int         gap;
    sched_rsp_t model;
    gap = req_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= rq.func;
    req_ch.task_id     <= rq.task_id;
    req_ch.period      <= rq.period;
    req_ch.first_delay <= rq.first_delay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // Taken on this edge: advance the mirror even when the answer is typed in
    model = schedule_step(rq);
    owed_rsp_q.push_back(typed ? want : model);
    n_reqs++;
    if (rq.func == ptts_pkg::OP_TICK) n_ticks++;
    n_fires   += $countones(model.fire_mask);
    n_created += int'(model.create_accepted);
  endtask

  // Reset and stimulus
  initial begin : stim
    sched_req_t rq;
    int         pick;
    req_ch.valid       = 1'b0;
    req_ch.func        = ptts_pkg::OP_TICK;
    req_ch.task_id     = '0;
    req_ch.period      = '0;
    req_ch.first_delay = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      slot_used_m[i]  = 1'b0;
      slot_ready_m[i] = 1'b0;
      countdown_m[i]  = '0;
      reload_m[i]     = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: corner values, every operation, every odd case
    foreach (DIR_TAB[i]) issue(DIR_TAB[i].rq, DIR_TAB[i].typed, DIR_TAB[i].want);

    // Random traffic, tick-heavy so that created slots keep counting and firing
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) req_gaps_on = ($urandom_range(0, 3) != 0);
      pick           = $urandom_range(0, 99);
      rq.task_id     = ptts_pkg::ID_W'($urandom_range(0, (1 << ptts_pkg::ID_W) - 1));
      rq.period      = ptts_pkg::TIME_W'($urandom);
      rq.first_delay = ptts_pkg::TIME_W'($urandom);
      if (pick < 50) begin
        rq.func = ptts_pkg::OP_TICK;
      end else if (pick < 68) begin
        rq.func = ptts_pkg::OP_CREATE;
        // Keep most periods short so firings are frequent
        if ($urandom_range(0, 3) != 0) begin
          rq.period      = ptts_pkg::TIME_W'($urandom_range(0, 6));
          rq.first_delay = ptts_pkg::TIME_W'($urandom_range(0, 8));
        end
      end else if (pick < 78) begin
        rq.func = ptts_pkg::OP_RESUME;
      end else if (pick < 86) begin
        rq.func = ptts_pkg::OP_SUSPEND;
      end else if (pick < 94) begin
        rq.func = ptts_pkg::OP_KILL;
      end else begin
        rq.func = ptts_pkg::FUNC_W'($urandom_range(OP_RSVD5, OP_RSVD7));
      end
      issue(rq, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    // Drain: every owed response in, then a few walks' worth of quiet
    while (owed_rsp_q.size() != 0) @(posedge clk);
    repeat (2 * TASK_COUNT + 8) @(posedge clk);

    $display("Covered %0d requests: %0d ticks, %0d slot firings, %0d creates taken.",
             n_reqs, n_ticks, n_fires, n_created);
    $display("Checked %0d responses under random request gaps and response stalls.", n_rsps);
    if (errors == 0) begin
      $display("periodic_task_tick_scheduler regression: pass");
    end else begin
      $display("periodic_task_tick_scheduler regression: fail");
    end
    $finish;
  end

  // Response side: stall at random, compare each taken response with the oldest owed one
  initial begin : drain
    int         stall;
    bit         stalls_on;
    sched_rsp_t want;
    rsp_ch.ready = 1'b0;
    stalls_on    = 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (n_rsps % 50 == 0) stalls_on = ($urandom_range(0, 3) != 0);
      stall = stalls_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      n_rsps++;
      if (owed_rsp_q.size() == 0) begin
        $display("%0t: response with nothing owed: fire_mask=%h create_accepted=%b",
                 $time, rsp_ch.fire_mask, rsp_ch.create_accepted);
        errors++;
      end else begin
        want = owed_rsp_q.pop_front();
        if (rsp_ch.fire_mask !== want.fire_mask) begin
          $display("%0t: fire_mask mismatch: expected %h, got %h",
                   $time, want.fire_mask, rsp_ch.fire_mask);
          errors++;
        end
        if (rsp_ch.create_accepted !== want.create_accepted) begin
          $display("%0t: create_accepted mismatch: expected %b, got %b",
                   $time, want.create_accepted, rsp_ch.create_accepted);
          errors++;
        end
      end
    end
  end

  // Hang guard: count edges on which neither channel moves a request or response
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d responses still owed",
               $time, QUIET_LIMIT, owed_rsp_q.size());
      $display("periodic_task_tick_scheduler regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
